// ===== hdl/swr_pkg.sv =====
package swr_pkg;

    // sample width default and working widths
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int RATIO_W         = 32;
    localparam int DIVISOR_W       = 16;
    localparam int ROOT_W          = 16;
    localparam int ROOT_CLAMP_W    = 10;
    localparam int RESULT_W        = 14;

    // arithmetic constants
    localparam int unsigned RATIO_SCALE = 1000000;
    localparam int unsigned ROOT_CLAMP  = 999;
    localparam int unsigned ROOT_ONE    = 1000;
    localparam int unsigned SWR_SCALE   = 100;
    localparam int unsigned SWR_MAX     = 9999;
    localparam int unsigned SWR_UNITY   = 100;
    localparam int unsigned FWD_MIN     = 10;

endpackage

// ===== hdl/swr_divider.sv =====
module swr_divider (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [swr_pkg::RATIO_W-1:0]      dividend,
    input  logic [swr_pkg::DIVISOR_W-1:0]    divisor,
    output logic                             done,
    output logic [swr_pkg::RATIO_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(swr_pkg::RATIO_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(swr_pkg::RATIO_W - 1);

    logic                             busy_reg;
    logic                             done_reg;
    logic [CNT_W-1:0]                 count_reg;
    logic [swr_pkg::RATIO_W-1:0]      shift_reg;
    logic [swr_pkg::DIVISOR_W-1:0]    rem_reg;
    logic [swr_pkg::DIVISOR_W-1:0]    dsr_reg;

    logic [swr_pkg::DIVISOR_W:0]      trial;
    logic [swr_pkg::DIVISOR_W:0]      diff;
    logic                             fits;

    // one restoring step: bring down the next dividend bit and try the subtract
    always_comb
    begin
        trial = {rem_reg, shift_reg[swr_pkg::RATIO_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = (trial >= {1'b0, dsr_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (count_reg == LAST_STEP);
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath: quotient bits shift in behind the dividend
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            dsr_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[swr_pkg::RATIO_W-2:0], fits};
            rem_reg   <= fits ? diff[swr_pkg::DIVISOR_W-1:0] : trial[swr_pkg::DIVISOR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule

// ===== hdl/swr_root.sv =====
module swr_root (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [swr_pkg::RATIO_W-1:0]   radicand,
    output logic                          done,
    output logic [swr_pkg::ROOT_W-1:0]    root
);

    localparam int STEPS = swr_pkg::RATIO_W / 2;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

    logic                             busy_reg;
    logic                             done_reg;
    logic [CNT_W-1:0]                 count_reg;
    logic [swr_pkg::RATIO_W-1:0]      rem_reg;
    logic [swr_pkg::RATIO_W-1:0]      acc_reg;
    logic [swr_pkg::RATIO_W-1:0]      bit_reg;

    logic [swr_pkg::RATIO_W:0]        trial;
    logic                             fits;

    // one bit of the root per step
    always_comb
    begin
        trial = {1'b0, acc_reg} + {1'b0, bit_reg};
        fits  = ({1'b0, rem_reg} >= trial);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (count_reg == LAST_STEP);
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath: start with the top even bit and walk down two at a time
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= radicand;
            acc_reg <= '0;
            bit_reg <= {2'b01, {(swr_pkg::RATIO_W - 2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - trial[swr_pkg::RATIO_W-1:0];
                acc_reg <= (acc_reg >> 1) + bit_reg;
            end
            else
            begin
                acc_reg <= acc_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = acc_reg[swr_pkg::ROOT_W-1:0];

endmodule

// ===== hdl/swr_ratio_meter_core.sv =====
// sequence: a forward sample below 10 goes from S_IDLE straight to S_OUT with a unity result,
// otherwise the pair walks S_MUL, S_DIV1, S_ROOT, S_SCALE, S_DIV2 and S_OUT (each unit
// started from its _GO state), running two 32-step divisions and a 16-step root one after another
// flow: sample_stall holds off new pairs outside S_IDLE, also while S_OUT waits on result_stall;
// the next beat can be taken in the cycle after the result is issued
// reset: asynchronous active-low rst_n returns the sequencer to idle and drops result_valid
module swr_ratio_meter_core #(
    parameter int SAMPLE_BITS = swr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [SAMPLE_BITS-1:0]        forward_sample,
    input  logic [SAMPLE_BITS-1:0]        reflected_sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [swr_pkg::RESULT_W-1:0]  ratio_hundredths
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DIV1_GO,
        S_DIV1,
        S_ROOT_GO,
        S_ROOT,
        S_SCALE,
        S_DIV2_GO,
        S_DIV2,
        S_OUT
    } state_t;

    state_t                               state_reg;
    logic [SAMPLE_BITS-1:0]               fwd_reg;
    logic [SAMPLE_BITS-1:0]               refl_reg;
    logic [swr_pkg::RATIO_W-1:0]          work_reg;
    logic [swr_pkg::ROOT_CLAMP_W-1:0]     root_reg;
    logic [swr_pkg::RESULT_W-1:0]         swr_reg;
    logic                                 result_valid_reg;
    logic [swr_pkg::RESULT_W-1:0]         result_reg;

    logic                                 div_start;
    logic [swr_pkg::DIVISOR_W-1:0]        div_divisor;
    logic                                 div_done;
    logic [swr_pkg::RATIO_W-1:0]          div_quotient;
    logic                                 root_start;
    logic                                 root_done;
    logic [swr_pkg::ROOT_W-1:0]           root_value;
    logic                                 accept;
    logic                                 out_free;

    // handshake
    assign sample_stall = (state_reg != S_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign out_free     = !result_valid_reg || !result_stall;

    // operand selection for the shared divider
    assign div_start   = (state_reg == S_DIV1_GO) || (state_reg == S_DIV2_GO);
    assign div_divisor = (state_reg == S_DIV1_GO)
                       ? swr_pkg::DIVISOR_W'(fwd_reg)
                       : swr_pkg::DIVISOR_W'(swr_pkg::ROOT_ONE) - swr_pkg::DIVISOR_W'(root_reg);
    assign root_start  = (state_reg == S_ROOT_GO);

    swr_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (work_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    swr_root u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (work_reg),
        .done     (root_done),
        .root     (root_value)
    );

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            fwd_reg          <= '0;
            refl_reg         <= '0;
            work_reg         <= '0;
            root_reg         <= '0;
            swr_reg          <= '0;
            result_reg       <= '0;
        end
        else
        begin
            // result taken; a new result loading in the same cycle wins
            if (result_valid_reg && !result_stall && (state_reg != S_OUT))
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        fwd_reg  <= forward_sample;
                        refl_reg <= reflected_sample;
                        if (forward_sample < SAMPLE_BITS'(swr_pkg::FWD_MIN))
                        begin
                            swr_reg   <= swr_pkg::RESULT_W'(swr_pkg::SWR_UNITY);
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    work_reg  <= swr_pkg::RATIO_W'(refl_reg)
                               * swr_pkg::RATIO_W'(swr_pkg::RATIO_SCALE);
                    state_reg <= S_DIV1_GO;
                end
                S_DIV1_GO:
                begin
                    state_reg <= S_DIV1;
                end
                S_DIV1:
                begin
                    if (div_done)
                    begin
                        work_reg  <= div_quotient;
                        state_reg <= S_ROOT_GO;
                    end
                end
                S_ROOT_GO:
                begin
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (root_done)
                    begin
                        if (root_value > swr_pkg::ROOT_W'(swr_pkg::ROOT_CLAMP))
                        begin
                            root_reg <= swr_pkg::ROOT_CLAMP_W'(swr_pkg::ROOT_CLAMP);
                        end
                        else
                        begin
                            root_reg <= root_value[swr_pkg::ROOT_CLAMP_W-1:0];
                        end
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    work_reg  <= (swr_pkg::RATIO_W'(swr_pkg::ROOT_ONE)
                                  + swr_pkg::RATIO_W'(root_reg))
                               * swr_pkg::RATIO_W'(swr_pkg::SWR_SCALE);
                    state_reg <= S_DIV2_GO;
                end
                S_DIV2_GO:
                begin
                    state_reg <= S_DIV2;
                end
                S_DIV2:
                begin
                    if (div_done)
                    begin
                        if (div_quotient > swr_pkg::RATIO_W'(swr_pkg::SWR_MAX))
                        begin
                            swr_reg <= swr_pkg::RESULT_W'(swr_pkg::SWR_MAX);
                        end
                        else
                        begin
                            swr_reg <= div_quotient[swr_pkg::RESULT_W-1:0];
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        result_reg       <= swr_reg;
                        result_valid_reg <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid     = result_valid_reg;
    assign ratio_hundredths = result_reg;

endmodule
